// ===== hdl/sah_pkg.sv =====
// Shared constants and types for the split-plane sweep block.
// Holds coordinate widths, event and axis codes and configuration indexes.
// No dependencies.
package sah_pkg;

  localparam int COORD_BITS             = 16;
  localparam int DEF_MAX_PRIMITIVES     = 4096;
  localparam int DEF_TRAVERSAL_COST     = 1;
  localparam int QUEUE_DEPTH            = 4;
  localparam int PCOUNT_W               = 13;
  localparam int COST_W                 = 32;
  localparam int AREA_W                 = 34;
  localparam int CFG_IDX_W              = 3;
  localparam int CFG_DATA_W             = 16;

  typedef logic [1:0]              axis_t;
  typedef logic [1:0]              evtype_t;
  typedef logic [COORD_BITS-1:0]   coord_t;
  typedef logic [CFG_IDX_W-1:0]    cfg_idx_t;

  localparam axis_t AXIS_X       = 2'd0;
  localparam axis_t AXIS_Y       = 2'd1;
  localparam axis_t AXIS_Z       = 2'd2;
  localparam axis_t AXIS_BAD     = 2'd3;

  localparam evtype_t EV_END     = 2'd0;
  localparam evtype_t EV_PLANAR  = 2'd1;
  localparam evtype_t EV_START   = 2'd2;
  localparam evtype_t EV_BAD     = 2'd3;

  localparam cfg_idx_t REG_BOX_MIN_X    = 3'd0;
  localparam cfg_idx_t REG_BOX_MIN_Y    = 3'd1;
  localparam cfg_idx_t REG_BOX_MIN_Z    = 3'd2;
  localparam cfg_idx_t REG_BOX_MAX_X    = 3'd3;
  localparam cfg_idx_t REG_BOX_MAX_Y    = 3'd4;
  localparam cfg_idx_t REG_BOX_MAX_Z    = 3'd5;
  localparam cfg_idx_t REG_PRIM_COUNT   = 3'd6;
  localparam cfg_idx_t REG_ISECT_COST   = 3'd7;

  localparam logic [7:0] ISECT_COST_RESET = 8'd80;

endpackage

// ===== hdl/sah_fifo.sv =====
// Short queue of closed-run records between the front and back parts.
// Generic width and depth; no package dependencies.
module sah_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         not_empty,
  output logic [W-1:0] pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH + 1);

  logic [W-1:0]   slot_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNW-1:0] count_r;

  assign full      = (count_r == CNW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/sah_div.sv =====
// Restoring divider, one quotient bit per cycle, 32-bit quotient.
// Flags overflow when the quotient would not fit. Uses sah_pkg.
module sah_div #(
  parameter int DW = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [DW-1:0]             num,
  input  logic [sah_pkg::AREA_W-1:0] den,
  output logic                      done,
  output logic [sah_pkg::COST_W-1:0] quo,
  output logic                      ovf
);

  localparam int QW  = sah_pkg::COST_W;
  localparam int RW  = sah_pkg::AREA_W;
  localparam int HW  = (DW - QW > RW) ? DW - QW : RW;
  localparam int CW  = $clog2(QW + 1);

  logic          busy_r;
  logic [CW-1:0] cnt_r;
  logic [RW-1:0] rem_r;
  logic [RW-1:0] den_r;
  logic [QW-1:0] lo_r;
  logic [QW-1:0] q_r;
  logic          ovf_r;
  logic          done_r;
  logic [HW-1:0] hi_ext;
  logic [RW:0]   trial;
  logic          ge;

  assign hi_ext = HW'(num[DW-1:QW]);
  assign trial  = {rem_r, lo_r[QW-1]};
  assign ge     = (trial >= {1'b0, den_r});
  assign done   = done_r;
  assign quo    = q_r;
  assign ovf    = ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        den_r <= den;
        lo_r  <= num[QW-1:0];
        q_r   <= '0;
        if (hi_ext >= HW'(den)) begin
          ovf_r  <= 1'b1;
          done_r <= 1'b1;
        end else begin
          ovf_r  <= 1'b0;
          rem_r  <= hi_ext[RW-1:0];
          busy_r <= 1'b1;
          cnt_r  <= CW'(QW);
        end
      end else if (busy_r) begin
        rem_r <= ge ? RW'(trial - {1'b0, den_r}) : trial[RW-1:0];
        lo_r  <= {lo_r[QW-2:0], 1'b0};
        q_r   <= {q_r[QW-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/sah_front.sv =====
// Front part: accepts events, groups them into runs and queues closed runs.
// Each record carries axis, position and end/planar/start counts. Uses sah_pkg.
module sah_front #(
  parameter int MAX_PRIMITIVES = sah_pkg::DEF_MAX_PRIMITIVES,
  parameter int CW             = 13,
  parameter int EW             = 3 * 13 + 20
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  sah_pkg::axis_t           in_axis,
  input  sah_pkg::coord_t          in_position,
  input  sah_pkg::evtype_t         in_event_type,
  input  logic                     in_last_event,
  input  logic                     q_full,
  output logic                     push,
  output logic [EW-1:0]            push_data
);

  logic                   run_open_r;
  sah_pkg::axis_t         run_axis_r;
  sah_pkg::coord_t        run_pos_r;
  sah_pkg::evtype_t       run_last_type_r;
  logic [CW-1:0]          cnt_r [3];
  logic                   pend_r;
  logic [EW-1:0]          pend_data_r;

  logic                   accept, valid_ev, cont, close_old;
  logic [CW-1:0]          n_cnt [3];
  logic [CW:0]            inc;
  logic [EW-1:0]          old_ent, fin_ent;

  assign in_ready = !pend_r && !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    valid_ev  = (in_axis != sah_pkg::AXIS_BAD) && (in_event_type != sah_pkg::EV_BAD);
    cont      = run_open_r && (in_axis == run_axis_r) && (in_position == run_pos_r)
                && (in_event_type >= run_last_type_r);
    close_old = valid_ev && !cont && run_open_r;
    inc       = '0;
    for (int i = 0; i < 3; i++) begin
      n_cnt[i] = (valid_ev && !cont) ? '0 : cnt_r[i];
      if (valid_ev && (in_event_type == 2'(i))) begin
        inc      = {1'b0, n_cnt[i]} + 1'b1;
        n_cnt[i] = (inc > (CW + 1)'(MAX_PRIMITIVES)) ? CW'(MAX_PRIMITIVES) : inc[CW-1:0];
      end
    end
    old_ent = {1'b0, 1'b1, run_axis_r, run_pos_r, cnt_r[2], cnt_r[1], cnt_r[0]};
    fin_ent = {1'b1, (run_open_r | valid_ev),
               valid_ev ? in_axis : run_axis_r,
               valid_ev ? in_position : run_pos_r,
               n_cnt[2], n_cnt[1], n_cnt[0]};
    push      = 1'b0;
    push_data = fin_ent;
    if (pend_r) begin
      push      = !q_full;
      push_data = pend_data_r;
    end else if (accept) begin
      if (close_old) begin
        push      = 1'b1;
        push_data = old_ent;
      end else if (in_last_event) begin
        push      = 1'b1;
        push_data = fin_ent;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_open_r      <= 1'b0;
      run_axis_r      <= sah_pkg::AXIS_X;
      run_pos_r       <= '0;
      run_last_type_r <= sah_pkg::EV_END;
      pend_r          <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      if (pend_r && !q_full) begin
        pend_r <= 1'b0;
      end
      if (accept) begin
        if (close_old && in_last_event) begin
          pend_r      <= 1'b1;
          pend_data_r <= fin_ent;
        end
        if (in_last_event) begin
          run_open_r      <= 1'b0;
          run_axis_r      <= sah_pkg::AXIS_X;
          run_pos_r       <= '0;
          run_last_type_r <= sah_pkg::EV_END;
          for (int i = 0; i < 3; i++) begin
            cnt_r[i] <= '0;
          end
        end else if (valid_ev) begin
          run_open_r      <= 1'b1;
          run_axis_r      <= in_axis;
          run_pos_r       <= in_position;
          run_last_type_r <= in_event_type;
          for (int i = 0; i < 3; i++) begin
            cnt_r[i] <= n_cnt[i];
          end
        end
      end
    end
  end

endmodule

// ===== hdl/sah_back.sv =====
// Back part: updates per-axis counts, prices each plane and keeps the best.
// Drives the result register. Uses sah_pkg and sah_div.
module sah_back #(
  parameter int MAX_PRIMITIVES = sah_pkg::DEF_MAX_PRIMITIVES,
  parameter int TRAVERSAL_COST = sah_pkg::DEF_TRAVERSAL_COST,
  parameter int CW             = 13,
  parameter int EW             = 3 * 13 + 20
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_not_empty,
  input  logic [EW-1:0]                      q_data,
  output logic                               pop,
  input  logic [2:0][sah_pkg::COORD_BITS-1:0] box_lo,
  input  logic [2:0][sah_pkg::COORD_BITS-1:0] box_hi,
  input  logic [sah_pkg::PCOUNT_W-1:0]       pcount,
  input  logic                               pcount_wr,
  input  logic [sah_pkg::PCOUNT_W-1:0]       pcount_wdata,
  input  logic [7:0]                         isect_cost,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_found,
  output sah_pkg::axis_t                     out_best_axis,
  output sah_pkg::coord_t                    out_best_position,
  output logic [sah_pkg::COST_W-1:0]         out_best_cost,
  output logic                               out_planar_to_right
);

  localparam int XB  = sah_pkg::COORD_BITS;
  localparam int AW  = sah_pkg::AREA_W;
  localparam int NW  = CW + 1;
  localparam int MYW = (NW > 17) ? NW : 17;
  localparam int PW  = AW + MYW;
  localparam int SW  = AW + NW + 1;
  localparam int DW  = SW + 16;
  localparam int KW  = 16;
  localparam int LW  = 18;
  localparam int QW  = sah_pkg::COST_W;
  localparam logic [QW:0]   TRAV = (QW + 1)'(TRAVERSAL_COST * 256);
  localparam logic [QW-1:0] ONES = '1;
  // ceil(2^34 / 5): for any 32-bit x, floor(x / 5) is (x * RECIP5) >> 34.
  localparam logic [QW-1:0] RECIP5 = 32'hCCCC_CCCD;
  localparam int            RSH    = 34;

  typedef enum logic [4:0] {
    S_IDLE, S_UPD, S_EXT, S_BC, S_AT, S_AL, S_AR, S_CHK, S_S1, S_S2,
    S_D1, S_D2, S_DGO, S_DWT, S_BON, S_BON2, S_PICK, S_FIN, S_EMIT
  } state_t;

  function automatic logic [XB-1:0] extent(input logic [XB-1:0] lo, input logic [XB-1:0] hi);
    logic [XB:0] d;
    d = {hi[XB-1], hi} - {lo[XB-1], lo};
    return ($signed(hi) > $signed(lo)) ? d[XB-1:0] : '0;
  endfunction

  function automatic logic [CW-1:0] sat_cnt(input logic [LW-1:0] v);
    return (v > LW'(MAX_PRIMITIVES)) ? CW'(MAX_PRIMITIVES) : v[CW-1:0];
  endfunction

  state_t             state_r;
  logic [EW-1:0]      ent_r;
  logic [CW-1:0]      left_r [3];
  logic [CW-1:0]      right_r [3];
  logic [CW-1:0]      nl_r, np_r, nr_r;
  logic [XB-1:0]      lo_r, hi_r, pc_r;
  logic [XB-1:0]      ea_r, eb_r, ec_r, el_r, er_r;
  logic [2*XB-1:0]    bc_r;
  logic [XB:0]        sbc_r;
  logic [AW-1:0]      at_r, al_r, ar_r;
  logic [SW-1:0]      s_r;
  logic [DW-1:0]      d_r, div_num_r;
  logic [AW-1:0]      div_den_r;
  logic               side_r;
  logic [1:0]         bcnt_r, bl_r, br_r;
  logic [QW-1:0]      cl_r;
  logic [QW-1:0]      cur_r;
  logic [QW-3:0]      q5_r;
  logic               found_r, best_side_r;
  sah_pkg::axis_t     best_axis_r;
  sah_pkg::coord_t    best_pos_r;
  logic [QW-1:0]      best_cost_r;
  logic               out_valid_r;

  logic [CW-1:0]          e_ne, e_np, e_ns;
  sah_pkg::coord_t        e_pos;
  sah_pkg::axis_t         e_ax;
  logic                   e_run, e_last;
  logic [AW-1:0]          mx;
  logic [MYW-1:0]         my;
  logic [PW-1:0]          prod;
  logic                   div_start, div_done, div_ovf;
  logic [QW-1:0]          div_q;
  logic [XB-1:0]          lo_a, hi_a, pc_a;
  logic [XB-1:0]          ext [3];
  logic [NW-1:0]          nlp, npr;
  logic [QW:0]            csum;
  logic [QW-1:0]          cval, pick_cost;
  logic                   pick_side;
  logic [2*QW-1:0]        m5;
  logic [2:0]             rem5;
  logic [QW-1:0]          bon_val;
  logic [CW:0]            gone;
  logic [CW-1:0]          rc_new;

  assign e_ne   = ent_r[CW-1:0];
  assign e_np   = ent_r[2*CW-1:CW];
  assign e_ns   = ent_r[3*CW-1:2*CW];
  assign e_pos  = ent_r[3*CW+XB-1:3*CW];
  assign e_ax   = ent_r[3*CW+XB+1:3*CW+XB];
  assign e_run  = ent_r[3*CW+XB+2];
  assign e_last = ent_r[3*CW+XB+3];

  assign pop       = (state_r == S_IDLE) && q_not_empty;
  assign div_start = (state_r == S_DGO);
  assign nlp       = {1'b0, nl_r} + {1'b0, np_r};
  assign npr       = {1'b0, np_r} + {1'b0, nr_r};
  assign gone      = {1'b0, e_ne} + {1'b0, e_np};
  assign rc_new    = ({1'b0, right_r[e_ax]} > gone)
                     ? CW'({1'b0, right_r[e_ax]} - gone) : '0;

  assign out_valid = out_valid_r;

  always_comb begin
    unique case (e_ax)
      sah_pkg::AXIS_Y: begin lo_a = box_lo[1]; hi_a = box_hi[1]; end
      sah_pkg::AXIS_Z: begin lo_a = box_lo[2]; hi_a = box_hi[2]; end
      default:         begin lo_a = box_lo[0]; hi_a = box_hi[0]; end
    endcase
    if ($signed(e_pos) < $signed(lo_a)) begin
      pc_a = lo_a;
    end else if ($signed(e_pos) > $signed(hi_a)) begin
      pc_a = hi_a;
    end else begin
      pc_a = e_pos;
    end
    for (int i = 0; i < 3; i++) begin
      ext[i] = extent(box_lo[i], box_hi[i]);
    end
  end

  always_comb begin
    mx = '0;
    my = '0;
    unique case (state_r)
      S_BC: begin mx = AW'(eb_r);  my = MYW'(ec_r); end
      S_AT: begin mx = AW'(ea_r);  my = MYW'(sbc_r); end
      S_AL: begin mx = AW'(el_r);  my = MYW'(sbc_r); end
      S_AR: begin mx = AW'(er_r);  my = MYW'(sbc_r); end
      S_S1: begin mx = al_r; my = side_r ? MYW'(nl_r) : MYW'(nlp); end
      S_S2: begin mx = ar_r; my = side_r ? MYW'(npr) : MYW'(nr_r); end
      S_D1: begin mx = AW'(s_r[24:0]);    my = MYW'({isect_cost, 8'd0}); end
      S_D2: begin mx = AW'(s_r[SW-1:25]); my = MYW'({isect_cost, 8'd0}); end
      default: begin mx = '0; my = '0; end
    endcase
    prod = PW'(mx) * PW'(my);
  end

  always_comb begin
    csum = TRAV + {1'b0, div_q};
    if (div_ovf || csum[QW]) begin
      cval = ONES;
    end else begin
      cval = csum[QW-1:0];
    end
    // Bonus step: floor(4c/5) = 4q + max(r - 1, 0) with c = 5q + r.
    m5      = (2*QW)'(cur_r) * (2*QW)'(RECIP5);
    rem5    = 3'(cur_r - ({q5_r, 2'b00} + QW'(q5_r)));
    bon_val = {q5_r, 2'b00} + QW'((rem5 != 3'd0) ? rem5 - 3'd1 : 3'd0);
    if (cur_r < cl_r) begin
      pick_cost = cur_r;
      pick_side = 1'b1;
    end else begin
      pick_cost = cl_r;
      pick_side = 1'b0;
    end
  end

  sah_div #(.DW(DW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num_r),
    .den   (div_den_r),
    .done  (div_done),
    .quo   (div_q),
    .ovf   (div_ovf)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      best_cost_r <= ONES;
      best_axis_r <= sah_pkg::AXIS_X;
      best_pos_r  <= '0;
      best_side_r <= 1'b0;
      side_r      <= 1'b0;
      bcnt_r      <= '0;
      for (int i = 0; i < 3; i++) begin
        left_r[i]  <= '0;
        right_r[i] <= '0;
      end
    end else begin
      if (out_valid_r && out_ready && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      if (pcount_wr) begin
        for (int i = 0; i < 3; i++) begin
          right_r[i] <= sat_cnt(LW'(pcount_wdata));
        end
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_not_empty) begin
            ent_r   <= q_data;
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          if (e_run) begin
            right_r[e_ax] <= rc_new;
            left_r[e_ax]  <= sat_cnt(LW'(left_r[e_ax]) + LW'(e_np) + LW'(e_ns));
            nl_r    <= left_r[e_ax];
            np_r    <= e_np;
            nr_r    <= rc_new;
            lo_r    <= lo_a;
            hi_r    <= hi_a;
            pc_r    <= pc_a;
            state_r <= ($signed(lo_a) < $signed(hi_a)) ? S_EXT : S_FIN;
          end else begin
            state_r <= S_FIN;
          end
        end
        S_EXT: begin
          el_r <= extent(lo_r, pc_r);
          er_r <= extent(pc_r, hi_r);
          unique case (e_ax)
            sah_pkg::AXIS_Y: begin ea_r <= ext[1]; eb_r <= ext[2]; ec_r <= ext[0]; end
            sah_pkg::AXIS_Z: begin ea_r <= ext[2]; eb_r <= ext[0]; ec_r <= ext[1]; end
            default:         begin ea_r <= ext[0]; eb_r <= ext[1]; ec_r <= ext[2]; end
          endcase
          // Empty-side bonus counts; a side can earn the bonus twice.
          bl_r <= 2'({1'b0, ($signed(pc_r) > $signed(lo_r)) && (nlp == '0)})
                + 2'({1'b0, ($signed(pc_r) < $signed(hi_r)) && (nr_r == '0)});
          br_r <= 2'({1'b0, ($signed(pc_r) > $signed(lo_r)) && (nl_r == '0)})
                + 2'({1'b0, ($signed(pc_r) < $signed(hi_r)) && (npr == '0)});
          state_r <= S_BC;
        end
        S_BC: begin
          bc_r    <= prod[2*XB-1:0];
          sbc_r   <= {1'b0, eb_r} + {1'b0, ec_r};
          state_r <= S_AT;
        end
        S_AT: begin
          at_r    <= prod[AW-1:0] + AW'(bc_r);
          state_r <= S_AL;
        end
        S_AL: begin
          al_r    <= prod[AW-1:0] + AW'(bc_r);
          state_r <= S_AR;
        end
        S_AR: begin
          ar_r    <= prod[AW-1:0] + AW'(bc_r);
          state_r <= S_CHK;
        end
        S_CHK: begin
          side_r  <= 1'b0;
          state_r <= (at_r == '0) ? S_FIN : S_S1;
        end
        S_S1: begin
          s_r     <= SW'(prod);
          state_r <= S_S2;
        end
        S_S2: begin
          s_r     <= s_r + SW'(prod);
          state_r <= S_D1;
        end
        S_D1: begin
          d_r     <= DW'(prod);
          state_r <= S_D2;
        end
        S_D2: begin
          div_num_r <= d_r + (DW'(prod) << 25);
          div_den_r <= at_r;
          bcnt_r    <= side_r ? br_r : bl_r;
          state_r   <= S_DGO;
        end
        S_DGO: begin
          state_r <= S_DWT;
        end
        S_DWT: begin
          if (div_done) begin
            cur_r   <= cval;
            state_r <= S_BON;
          end
        end
        S_BON: begin
          if (bcnt_r != '0) begin
            // Bonus: cost * 4 / 5 by reciprocal multiplication, split over S_BON and S_BON2.
            q5_r    <= m5[2*QW-1:RSH];
            state_r <= S_BON2;
          end else if (!side_r) begin
            cl_r    <= cur_r;
            side_r  <= 1'b1;
            state_r <= S_S1;
          end else begin
            if (!found_r || (pick_cost < best_cost_r)) begin
              found_r     <= 1'b1;
              best_cost_r <= pick_cost;
              best_axis_r <= e_ax;
              best_pos_r  <= e_pos;
              best_side_r <= pick_side;
            end
            state_r <= S_PICK;
          end
        end
        S_BON2: begin
          cur_r   <= bon_val;
          bcnt_r  <= bcnt_r - 1'b1;
          state_r <= S_BON;
        end
        S_PICK: begin
          state_r <= S_FIN;
        end
        S_FIN: begin
          state_r <= e_last ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r         <= 1'b1;
            out_found           <= found_r;
            out_best_axis       <= best_axis_r;
            out_best_position   <= best_pos_r;
            out_best_cost       <= best_cost_r;
            out_planar_to_right <= best_side_r;
            found_r     <= 1'b0;
            best_cost_r <= ONES;
            best_axis_r <= sah_pkg::AXIS_X;
            best_pos_r  <= '0;
            best_side_r <= 1'b0;
            for (int i = 0; i < 3; i++) begin
              left_r[i]  <= '0;
              right_r[i] <= sat_cnt(LW'(pcount));
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/sah_split_plane_sweep.sv =====
// Top level of the surface-area-heuristic split-plane sweep.
// Holds the configuration registers; instantiates sah_front, sah_fifo, sah_back.
//
// Usage: software writes the node box, the primitive count and the
// intersection cost through the cfg_ port while the block is idle, then
// streams the node's sorted split events on the in_ channel (valid/ready).
// Events of one axis and position with non-decreasing type form a run. The
// event flagged in_last_event closes the node, and exactly one result item
// (found, best axis, position, cost, planar side) appears on the out_ channel.
//
// Flow control: an event that extends the current run is taken whenever
// in_ready is high. An event that closes a run hands it to the back part
// through a four-entry queue; the back part prices one plane at a time, with
// the shared 32-step divider doing one division per placement, plus a
// reciprocal multiply for each empty-side bonus, up to four per plane. A
// division whose quotient overflows skips its quotient steps. Runs on flat
// axes are not priced. The result follows once the back part has finished
// its work, the final run included, and is loaded into the output register.
//
// Reset (synchronous, active low) empties the queue, clears the run and the
// best plane, loads intersection cost 80 and zeros the box and count. A
// stalled receiver holds the result in the output register; the block keeps
// accepting events until the queue fills.
module sah_split_plane_sweep #(
  parameter int MAX_PRIMITIVES = sah_pkg::DEF_MAX_PRIMITIVES,
  parameter int TRAVERSAL_COST = sah_pkg::DEF_TRAVERSAL_COST
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  sah_pkg::cfg_idx_t                 cfg_index,
  input  logic [sah_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  sah_pkg::axis_t                    in_axis,
  input  sah_pkg::coord_t                   in_position,
  input  sah_pkg::evtype_t                  in_event_type,
  input  logic                              in_last_event,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_found,
  output sah_pkg::axis_t                    out_best_axis,
  output sah_pkg::coord_t                   out_best_position,
  output logic [sah_pkg::COST_W-1:0]        out_best_cost,
  output logic                              out_planar_to_right
);

  // Counter width follows the largest primitive count.
  localparam int CW = $clog2(MAX_PRIMITIVES + 1);
  // Queue record: last flag, run flag, axis, position and three type counts.
  localparam int EW = 3 * CW + sah_pkg::COORD_BITS + 4;

  logic [2:0][sah_pkg::COORD_BITS-1:0] box_lo_r, box_hi_r;
  logic [sah_pkg::PCOUNT_W-1:0]        pcount_r;
  logic [7:0]                          isect_cost_r;
  logic                                pcount_wr;

  logic                q_full, q_push, q_pop, q_not_empty;
  logic [EW-1:0]       q_push_data, q_pop_data;

  assign pcount_wr = cfg_wr_en && (cfg_index == sah_pkg::REG_PRIM_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_lo_r     <= '0;
      box_hi_r     <= '0;
      pcount_r     <= '0;
      isect_cost_r <= sah_pkg::ISECT_COST_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        sah_pkg::REG_BOX_MIN_X:  box_lo_r[0]  <= cfg_data;
        sah_pkg::REG_BOX_MIN_Y:  box_lo_r[1]  <= cfg_data;
        sah_pkg::REG_BOX_MIN_Z:  box_lo_r[2]  <= cfg_data;
        sah_pkg::REG_BOX_MAX_X:  box_hi_r[0]  <= cfg_data;
        sah_pkg::REG_BOX_MAX_Y:  box_hi_r[1]  <= cfg_data;
        sah_pkg::REG_BOX_MAX_Z:  box_hi_r[2]  <= cfg_data;
        sah_pkg::REG_PRIM_COUNT: pcount_r     <= cfg_data[sah_pkg::PCOUNT_W-1:0];
        sah_pkg::REG_ISECT_COST: isect_cost_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  sah_front #(
    .MAX_PRIMITIVES (MAX_PRIMITIVES),
    .CW             (CW),
    .EW             (EW)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_axis       (in_axis),
    .in_position   (in_position),
    .in_event_type (in_event_type),
    .in_last_event (in_last_event),
    .q_full        (q_full),
    .push          (q_push),
    .push_data     (q_push_data)
  );

  sah_fifo #(
    .W     (EW),
    .DEPTH (sah_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_pop_data)
  );

  sah_back #(
    .MAX_PRIMITIVES (MAX_PRIMITIVES),
    .TRAVERSAL_COST (TRAVERSAL_COST),
    .CW             (CW),
    .EW             (EW)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_not_empty         (q_not_empty),
    .q_data              (q_pop_data),
    .pop                 (q_pop),
    .box_lo              (box_lo_r),
    .box_hi              (box_hi_r),
    .pcount              (pcount_r),
    .pcount_wr           (pcount_wr),
    .pcount_wdata        (cfg_data[sah_pkg::PCOUNT_W-1:0]),
    .isect_cost          (isect_cost_r),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_found           (out_found),
    .out_best_axis       (out_best_axis),
    .out_best_position   (out_best_position),
    .out_best_cost       (out_best_cost),
    .out_planar_to_right (out_planar_to_right)
  );

endmodule

// ===== verif/sah_split_plane_sweep_tb.sv =====
// Self-checking testbench for the surface-area-heuristic split-plane sweep.
// Depends on sah_pkg and sah_split_plane_sweep; predicts every result item
// from its own model of the sweep and compares the out_ channel against it.
module sah_split_plane_sweep_tb;

  localparam int MAXP         = sah_pkg::DEF_MAX_PRIMITIVES;
  localparam int RANDOM_ITEMS = 850;
  // The back part may still hold four queued planes when the checks finish.
  localparam int SETTLE       = 1200;

  typedef struct {
    logic                       found;
    sah_pkg::axis_t             ax;
    sah_pkg::coord_t            pos;
    logic [sah_pkg::COST_W-1:0] cost;
    logic                       side;
  } plane_t;

  typedef struct {
    sah_pkg::axis_t   ax;
    sah_pkg::coord_t  pos;
    sah_pkg::evtype_t ty;
    logic             last;
  } event_item_t;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  sah_pkg::cfg_idx_t cfg_index = sah_pkg::REG_BOX_MIN_X;
  logic [sah_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  sah_pkg::axis_t in_axis = sah_pkg::AXIS_X;
  sah_pkg::coord_t in_position = '0;
  sah_pkg::evtype_t in_event_type = sah_pkg::EV_END;
  logic in_last_event = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_found;
  sah_pkg::axis_t out_best_axis;
  sah_pkg::coord_t out_best_position;
  logic [sah_pkg::COST_W-1:0] out_best_cost;
  logic out_planar_to_right;

  sah_split_plane_sweep i_dut (
    .clk, .rst_n, .cfg_wr_en, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .in_axis, .in_position, .in_event_type, .in_last_event,
    .out_valid, .out_ready, .out_found, .out_best_axis, .out_best_position,
    .out_best_cost, .out_planar_to_right
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Stimulus queue feeding the driver, and the planes we expect to see.
  event_item_t pending_events[$];
  plane_t      expected_planes[$];
  int          errors = 0;
  int          items_queued = 0;
  int          nodes_run = 0;
  int          planes_seen = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  // Predictor state: configuration registers and the sweep's own state.
  int          box_lo[3];
  int          box_hi[3];
  int          prim_count;
  int          isect_cost;
  longint      left_cnt[3];
  longint      right_cnt[3];
  longint      run_type_cnt[3];
  bit          run_open;
  int          run_axis;
  int          run_pos;
  int          run_last_type;
  longint      best_cost;
  int          best_axis;
  int          best_pos;
  int          best_side;
  bit          best_found;

  function automatic longint sat_count(longint v);
    return (v > MAXP) ? MAXP : v;
  endfunction

  function automatic longint extent_of(int lo, int hi);
    return (hi <= lo) ? 0 : longint'(hi - lo);
  endfunction

  function automatic longint area_of(longint e0, longint e1, longint e2);
    return e0 * e1 + e1 * e2 + e2 * e0;
  endfunction

  // Exact floor of traversal + C*256*(AL*n1 + AR*n2)/A, saturated to 32 bits.
  function automatic longint placement_cost(longint al, longint n1, longint ar,
                                            longint n2, longint a);
    longint s;
    longint k;
    longint v;
    s = al * n1 + ar * n2;
    k = longint'(isect_cost) * 256;
    v = longint'(sah_pkg::DEF_TRAVERSAL_COST) * 256 + k * (s / a) + (k * (s % a)) / a;
    return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
  endfunction

  function automatic void price_plane(int a, int pos, longint nl, longint np, longint nr);
    int     lo;
    int     hi;
    int     p;
    longint e[3];
    longint el[3];
    longint er[3];
    longint at;
    longint al;
    longint ar;
    longint cl;
    longint cr;
    longint c;
    int     side;
    lo = box_lo[a];
    hi = box_hi[a];
    // The plane is clamped into the box for pricing; the reported spot is not.
    p = (pos < lo) ? lo : ((pos > hi) ? hi : pos);
    for (int i = 0; i < 3; i++) begin
      e[i] = extent_of(box_lo[i], box_hi[i]);
      el[i] = e[i];
      er[i] = e[i];
    end
    el[a] = extent_of(lo, p);
    er[a] = extent_of(p, hi);
    at = area_of(e[0], e[1], e[2]);
    if (at == 0) return;
    al = area_of(el[0], el[1], el[2]);
    ar = area_of(er[0], er[1], er[2]);
    cl = placement_cost(al, nl + np, ar, nr, at);
    cr = placement_cost(al, nl, ar, np + nr, at);
    // Empty-side bonus, which can hit one placement twice.
    if (p > lo) begin
      if (nl + np == 0) cl = cl * 4 / 5;
      if (nl == 0) cr = cr * 4 / 5;
    end
    if (p < hi) begin
      if (nr == 0) cl = cl * 4 / 5;
      if (np + nr == 0) cr = cr * 4 / 5;
    end
    c = cl;
    side = 0;
    if (cr < cl) begin
      c = cr;
      side = 1;
    end
    if (!best_found || c < best_cost) begin
      best_found = 1'b1;
      best_cost = c;
      best_axis = a;
      best_pos = pos;
      best_side = side;
    end
  endfunction

  function automatic void close_plane_run();
    longint gone;
    gone = run_type_cnt[sah_pkg::EV_END] + run_type_cnt[sah_pkg::EV_PLANAR];
    right_cnt[run_axis] = (right_cnt[run_axis] > gone) ? right_cnt[run_axis] - gone : 0;
    if (box_lo[run_axis] < box_hi[run_axis])
      price_plane(run_axis, run_pos, left_cnt[run_axis], run_type_cnt[sah_pkg::EV_PLANAR],
                  right_cnt[run_axis]);
    left_cnt[run_axis] = sat_count(left_cnt[run_axis] + run_type_cnt[sah_pkg::EV_PLANAR] +
                                   run_type_cnt[sah_pkg::EV_START]);
    run_open = 1'b0;
  endfunction

  function automatic void clear_node();
    for (int i = 0; i < 3; i++) begin
      left_cnt[i] = 0;
      right_cnt[i] = sat_count(prim_count);
      run_type_cnt[i] = 0;
    end
    run_open = 1'b0;
    run_axis = 0;
    run_pos = 0;
    run_last_type = 0;
    best_cost = 64'hFFFF_FFFF;
    best_axis = 0;
    best_pos = 0;
    best_side = 0;
    best_found = 1'b0;
  endfunction

  function automatic void model_write(sah_pkg::cfg_idx_t idx,
                                      logic [sah_pkg::CFG_DATA_W-1:0] d);
    case (idx)
      sah_pkg::REG_BOX_MIN_X: box_lo[0] = int'($signed(d));
      sah_pkg::REG_BOX_MIN_Y: box_lo[1] = int'($signed(d));
      sah_pkg::REG_BOX_MIN_Z: box_lo[2] = int'($signed(d));
      sah_pkg::REG_BOX_MAX_X: box_hi[0] = int'($signed(d));
      sah_pkg::REG_BOX_MAX_Y: box_hi[1] = int'($signed(d));
      sah_pkg::REG_BOX_MAX_Z: box_hi[2] = int'($signed(d));
      sah_pkg::REG_PRIM_COUNT: begin
        prim_count = int'(d[sah_pkg::PCOUNT_W-1:0]);
        for (int i = 0; i < 3; i++) right_cnt[i] = sat_count(prim_count);
      end
      sah_pkg::REG_ISECT_COST: isect_cost = int'(d[7:0]);
      default: ;
    endcase
  endfunction

  // Advances the sweep by one accepted event; a closing event yields a plane.
  function automatic void sweep_event(event_item_t ev);
    int     p;
    int     ty;
    plane_t r;
    ty = int'(ev.ty);
    if (ev.ax != sah_pkg::AXIS_BAD && ev.ty != sah_pkg::EV_BAD) begin
      p = int'($signed(ev.pos));
      if (!(run_open && int'(ev.ax) == run_axis && p == run_pos && ty >= run_last_type)) begin
        if (run_open) close_plane_run();
        run_open = 1'b1;
        run_axis = int'(ev.ax);
        run_pos = p;
        for (int i = 0; i < 3; i++) run_type_cnt[i] = 0;
      end
      run_last_type = ty;
      run_type_cnt[ty] = sat_count(run_type_cnt[ty] + 1);
    end
    if (!ev.last) return;
    if (run_open) close_plane_run();
    r.found = best_found;
    r.ax = sah_pkg::axis_t'(best_axis);
    r.pos = sah_pkg::coord_t'(best_pos);
    r.cost = best_cost[sah_pkg::COST_W-1:0];
    r.side = best_side[0];
    expected_planes.insert(expected_planes.size(), r);
    clear_node();
  endfunction

  // Driver: presents queued events and feeds each accepted one to the model.
  always @(posedge clk) begin
    event_item_t ev;
    if (rst_n && in_valid && in_ready) begin
      ev.ax = in_axis;
      ev.pos = in_position;
      ev.ty = in_event_type;
      ev.last = in_last_event;
      sweep_event(ev);
    end
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_events.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        ev = pending_events.pop_front();
        in_valid <= 1'b1;
        in_axis <= ev.ax;
        in_position <= ev.pos;
        in_event_type <= ev.ty;
        in_last_event <= ev.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stalls and the result checker.
  always @(posedge clk) begin
    plane_t x;
    out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    if (rst_n && out_valid && out_ready) begin
      planes_seen++;
      if (expected_planes.size() == 0) begin
        $error("result item with no expected plane");
        errors++;
      end else begin
        x = expected_planes.pop_front();
        if (out_found !== x.found) begin
          $error("found: expected %0d, got %0d", x.found, out_found);
          errors++;
        end
        if (out_best_axis !== x.ax) begin
          $error("best_axis: expected %0d, got %0d", x.ax, out_best_axis);
          errors++;
        end
        if (out_best_position !== x.pos) begin
          $error("best_position: expected %0d, got %0d", $signed(x.pos),
                 $signed(out_best_position));
          errors++;
        end
        if (out_best_cost !== x.cost) begin
          $error("best_cost: expected %h, got %h", x.cost, out_best_cost);
          errors++;
        end
        if (out_planar_to_right !== x.side) begin
          $error("planar_to_right: expected %0d, got %0d", x.side, out_planar_to_right);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(sah_pkg::cfg_idx_t idx, logic [sah_pkg::CFG_DATA_W-1:0] d);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    model_write(idx, d);
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic write_box(int lx, int ly, int lz, int hx, int hy, int hz);
    write_reg(sah_pkg::REG_BOX_MIN_X, lx[15:0]);
    write_reg(sah_pkg::REG_BOX_MIN_Y, ly[15:0]);
    write_reg(sah_pkg::REG_BOX_MIN_Z, lz[15:0]);
    write_reg(sah_pkg::REG_BOX_MAX_X, hx[15:0]);
    write_reg(sah_pkg::REG_BOX_MAX_Y, hy[15:0]);
    write_reg(sah_pkg::REG_BOX_MAX_Z, hz[15:0]);
  endtask

  task automatic queue_event(sah_pkg::axis_t ax, int pos, sah_pkg::evtype_t ty, logic last);
    event_item_t ev;
    ev.ax = ax;
    ev.pos = pos[15:0];
    ev.ty = ty;
    ev.last = last;
    pending_events.insert(pending_events.size(), ev);
    items_queued++;
    // Idle pattern follows progress through the random part.
    if (items_queued < RANDOM_ITEMS / 3) begin
      send_idle_pct = 25;
      recv_idle_pct = 69;
    end else if (items_queued < 2 * RANDOM_ITEMS / 3) begin
      send_idle_pct = 69;
      recv_idle_pct = 25;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  // Waits until every event is taken and every plane checked, then lets the
  // back part finish any run that produced no result.
  task automatic drain();
    while (pending_events.size() != 0 || in_valid || expected_planes.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // One node of sorted events over a few candidate spots per axis, with a
  // sprinkling of malformed or unsorted events.
  task automatic random_node(int n);
    int spots[3][4];
    int keys[$];
    int k;
    int ax;
    int pos;
    logic [15:0] raw;
    for (int a = 0; a < 3; a++)
      for (int j = 0; j < 4; j++) begin
        if ($urandom_range(9) == 0)
          spots[a][j] = box_lo[a] + $urandom_range(400) - 200;
        else if (box_hi[a] > box_lo[a])
          spots[a][j] = box_lo[a] + $urandom_range(box_hi[a] - box_lo[a]);
        else
          spots[a][j] = box_lo[a];
        if (spots[a][j] > 32767) spots[a][j] = 32767;
        if (spots[a][j] < -32768) spots[a][j] = -32768;
      end
    for (int i = 0; i < n; i++) begin
      ax = $urandom_range(2);
      pos = spots[ax][$urandom_range(3)];
      raw = pos[15:0] ^ 16'h8000;
      keys.insert(keys.size(), (ax << 18) | (int'(raw) << 2) | int'($urandom_range(2)));
    end
    keys.sort();
    for (int i = 0; i < n; i++) begin
      k = keys[i];
      if ($urandom_range(11) == 0) begin
        raw = 16'($urandom);
        queue_event(sah_pkg::axis_t'($urandom_range(3)), int'(raw),
                    sah_pkg::evtype_t'($urandom_range(3)), i == n - 1);
      end else begin
        raw = k[17:2] ^ 16'h8000;
        queue_event(sah_pkg::axis_t'(k[19:18]), int'($signed(raw)),
                    sah_pkg::evtype_t'(k[1:0]), i == n - 1);
      end
    end
  endtask

  initial begin
    int lo[3];
    int hi[3];
    int n;
    for (int i = 0; i < 3; i++) begin
      box_lo[i] = 0;
      box_hi[i] = 0;
    end
    prim_count = 0;
    isect_cost = int'(sah_pkg::ISECT_COST_RESET);
    clear_node();
    send_idle_pct = 25;
    recv_idle_pct = 69;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset box is flat everywhere, so no plane is evaluated.
    queue_event(sah_pkg::AXIS_X, 0, sah_pkg::EV_START, 1'b1);
    drain();
    nodes_run++;

    // Full-range box, saturated count and top cost; runs of one position with
    // a type step down, an invalid axis and an invalid type in the stream.
    write_box(-32768, -32768, -32768, 32767, 32767, 32767);
    write_reg(sah_pkg::REG_PRIM_COUNT, 16'hFFFF);
    write_reg(sah_pkg::REG_ISECT_COST, 16'd255);
    end_writes();
    queue_event(sah_pkg::AXIS_X, -32768, sah_pkg::EV_END, 1'b0);
    queue_event(sah_pkg::AXIS_X, -32768, sah_pkg::EV_PLANAR, 1'b0);
    queue_event(sah_pkg::AXIS_X, 0, sah_pkg::EV_START, 1'b0);
    queue_event(sah_pkg::AXIS_X, 0, sah_pkg::EV_END, 1'b0);
    queue_event(sah_pkg::AXIS_BAD, 0, sah_pkg::EV_START, 1'b0);
    queue_event(sah_pkg::AXIS_Y, 0, sah_pkg::EV_BAD, 1'b0);
    queue_event(sah_pkg::AXIS_Y, -1, sah_pkg::EV_PLANAR, 1'b0);
    queue_event(sah_pkg::AXIS_Z, 32767, sah_pkg::EV_START, 1'b1);
    drain();
    nodes_run++;

    // Two flat axes give a zero node area; cost weight zero.
    write_box(0, 0, 0, 100, 0, 0);
    write_reg(sah_pkg::REG_ISECT_COST, 16'd0);
    write_reg(sah_pkg::REG_PRIM_COUNT, 16'd3);
    end_writes();
    queue_event(sah_pkg::AXIS_X, 50, sah_pkg::EV_PLANAR, 1'b0);
    queue_event(sah_pkg::AXIS_Z, 0, sah_pkg::EV_START, 1'b1);
    drain();
    nodes_run++;

    // Inverted x axis, planes outside the box on y, a plane on the z boundary, count underflow.
    write_box(100, 0, 0, 0, 100, 100);
    write_reg(sah_pkg::REG_PRIM_COUNT, 16'd0);
    write_reg(sah_pkg::REG_ISECT_COST, 16'd80);
    end_writes();
    queue_event(sah_pkg::AXIS_X, 50, sah_pkg::EV_END, 1'b0);
    queue_event(sah_pkg::AXIS_Y, -500, sah_pkg::EV_END, 1'b0);
    queue_event(sah_pkg::AXIS_Y, 500, sah_pkg::EV_PLANAR, 1'b0);
    queue_event(sah_pkg::AXIS_Z, 100, sah_pkg::EV_END, 1'b0);
    queue_event(sah_pkg::AXIS_Z, 100, sah_pkg::EV_PLANAR, 1'b1);
    drain();
    nodes_run++;

    // A node whose only event is invalid still closes with an empty result.
    queue_event(sah_pkg::AXIS_BAD, 7, sah_pkg::EV_BAD, 1'b1);
    drain();
    nodes_run++;

    items_queued = 0;
    while (items_queued < RANDOM_ITEMS) begin
      for (int a = 0; a < 3; a++) begin
        case ($urandom_range(9))
          0: begin
            lo[a] = -32768;
            hi[a] = 32767;
          end
          1: begin
            lo[a] = int'($signed(16'($urandom)));
            hi[a] = lo[a];
          end
          2: begin
            lo[a] = int'($signed(16'($urandom)));
            hi[a] = int'($signed(16'($urandom)));
          end
          default: begin
            lo[a] = $urandom_range(8000) - 4000;
            hi[a] = lo[a] + $urandom_range(6000);
          end
        endcase
      end
      n = $urandom_range(4, 36);
      write_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
      case ($urandom_range(7))
        0: write_reg(sah_pkg::REG_PRIM_COUNT, 16'($urandom));
        1: write_reg(sah_pkg::REG_PRIM_COUNT, 16'd0);
        default: write_reg(sah_pkg::REG_PRIM_COUNT, 16'($urandom_range(n)));
      endcase
      if ($urandom_range(2) == 0)
        write_reg(sah_pkg::REG_ISECT_COST, 16'($urandom));
      end_writes();
      random_node(n);
      drain();
      nodes_run++;
    end

    $display("Swept %0d nodes with %0d random events and checked %0d result items.",
             nodes_run, items_queued, planes_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
